[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk with arst_n as disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset
`define CHK_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be seen outside reset
`define CHK_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[rtl/pacs_pkg.sv]
// ----------------------------------------------------------------------------
// pacs_pkg
// Types, constants and Adam7 geometry helpers for the channel swap unit.
// ----------------------------------------------------------------------------
package pacs_pkg;

	// Dimension counters (rows, columns, image size)
	localparam int DIM_BITS   = 16;
	localparam int NUM_PASSES = 7;
	localparam int PASS_W     = 3;

	// Front-to-back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERLACE_ON = 2'd2;

	// Adam7 pass origins and log2 of the pass steps
	localparam logic [2:0] ADAM_X0  [NUM_PASSES] = '{3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd1, 3'd0};
	localparam logic [1:0] ADAM_XSH [NUM_PASSES] = '{2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};
	localparam logic [2:0] ADAM_Y0  [NUM_PASSES] = '{3'd0, 3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd1};
	localparam logic [1:0] ADAM_YSH [NUM_PASSES] = '{2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd1, 2'd1};

	// One queued transaction group: a single result or a three-byte release
	typedef struct packed {
		logic       triple;
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		logic       filt;
		logic       fend;
	} entry_t;

	// Number of samples of a pass along one axis (step is a power of two)
	function automatic logic [DIM_BITS-1:0] span(input logic [DIM_BITS-1:0] size,
			input logic [2:0] start, input logic [1:0] sh);
		logic [DIM_BITS:0] t;
		t = {1'b0, size} - (DIM_BITS+1)'(start) + (((DIM_BITS+1)'(1) << sh) - 1'b1);
		if (size <= DIM_BITS'(start))
			return '0;
		return DIM_BITS'(t >> sh);
	endfunction

	function automatic logic [DIM_BITS-1:0] pass_cols(input logic [DIM_BITS-1:0] w,
			input logic il, input logic [PASS_W-1:0] p);
		if (!il)
			return w;
		if (p >= PASS_W'(NUM_PASSES))
			return '0;
		return span(w, ADAM_X0[p], ADAM_XSH[p]);
	endfunction

	function automatic logic [DIM_BITS-1:0] pass_rows(input logic [DIM_BITS-1:0] w,
			input logic [DIM_BITS-1:0] h, input logic il, input logic [PASS_W-1:0] p);
		if (!il)
			return h;
		if (p >= PASS_W'(NUM_PASSES))
			return '0;
		if (pass_cols(w, il, p) == '0)
			return '0;
		return span(h, ADAM_Y0[p], ADAM_YSH[p]);
	endfunction

	// Lowest set position of a pass mask
	function automatic logic [PASS_W-1:0] lowest(input logic [NUM_PASSES-1:0] v);
		logic [PASS_W-1:0] idx;
		idx = '0;
		for (int i = NUM_PASSES - 1; i >= 0; i--) begin
			if (v[i])
				idx = PASS_W'(i);
		end
		return idx;
	endfunction

endpackage

[rtl/png_adam7_channel_swap_unit.sv]
// ----------------------------------------------------------------------------
// png_adam7_channel_swap_unit
// BGRA to RGBA swap on a filtered scanline stream with Adam7 geometry.
//
//   channel | direction | payload
//   --------+-----------+---------------------------------------------------
//   cfg     | in        | cfg_index (2 bits), cfg_data (16 bits)
//   in      | in        | in_byte
//   out     | out       | out_byte, run_last, is_filter_byte, frame_end
//
// One input byte is accepted per cycle unless the queue is full or the first
// pass is settling; results leave the output register at one per cycle while
// out_ready is high, four per four-byte pixel. The four-entry queue between
// classifier and output stage absorbs the three-byte release at pixel byte 2
// and lets either side stall alone. A known-register write restarts the frame
// and drops in_ready for one cycle. No clearing pass after reset.
// ----------------------------------------------------------------------------
module png_adam7_channel_swap_unit import pacs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 run_last,
	output logic                 is_filter_byte,
	output logic                 frame_end
);

`include "assert_macros.svh"

	entry_t push_entry, pop_entry;
	logic   q_push, q_pop, q_full, q_empty;

	pacs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_entry   (push_entry)
	);

	pacs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (push_entry),
		.full     (q_full),
		.pop      (q_pop),
		.rd_entry (pop_entry),
		.empty    (q_empty)
	);

	pacs_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_entry        (pop_entry),
		.q_empty        (q_empty),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.run_last       (run_last),
		.is_filter_byte (is_filter_byte),
		.frame_end      (frame_end)
	);

	// Queue never overruns or underruns
	`CHK_NEVER(a_q_no_overrun, q_push && q_full, "push into full queue")
	`CHK_NEVER(a_q_no_underrun, q_pop && q_empty, "pop from empty queue")
	// Frame end and filter bytes always close the results of their transaction
	`CHK_HOLDS(a_fend_last, out_valid && frame_end |-> run_last, "frame end not last")
	`CHK_HOLDS(a_filt_last, out_valid && is_filter_byte |-> run_last, "filter byte not last")

endmodule

[rtl/pacs_front.sv]
// ----------------------------------------------------------------------------
// pacs_front
// Holds configuration and scanline position, classifies each input byte and
// queues the results it releases.
// ----------------------------------------------------------------------------
module pacs_front import pacs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 q_full,
	output logic                 q_push,
	output entry_t               q_entry
);

	// Byte position within a pixel
	localparam logic [1:0] BYTE_0 = 2'd0;
	localparam logic [1:0] BYTE_1 = 2'd1;
	localparam logic [1:0] BYTE_2 = 2'd2;
	localparam logic [1:0] BYTE_3 = 2'd3;

	logic [DIM_BITS-1:0] width_q, height_q;
	logic                ilace_q;
	logic [PASS_W-1:0]   pass_q;
	logic [DIM_BITS-1:0] row_q, col_q;
	logic [1:0]          bip_q;
	logic                expect_q;
	logic                fixup_q;
	logic [7:0]          held1_q, held2_q;

	logic [DIM_BITS-1:0]   cur_cols, cur_rows;
	logic [NUM_PASSES-1:0] live, above;
	logic [PASS_W-1:0]     first_pass, next_pass;
	logic                  next_found, empty;
	logic [DIM_BITS:0]     row_inc, col_inc;
	logic                  row_done, frame_done, cols_zero, pix_done;
	logic                  accept, cfg_known, eos;

	assign cfg_ready = 1'b1;
	assign cfg_known = cfg_valid && (cfg_index == REG_IMAGE_WIDTH ||
		cfg_index == REG_IMAGE_HEIGHT || cfg_index == REG_INTERLACE_ON);

	// Geometry of the current pass and the set of passes with scanlines
	always_comb begin
		cur_cols = pass_cols(width_q, ilace_q, pass_q);
		cur_rows = pass_rows(width_q, height_q, ilace_q, pass_q);
		for (int i = 0; i < NUM_PASSES; i++) begin
			live[i]  = (ilace_q || i == 0) &&
				(pass_rows(width_q, height_q, ilace_q, PASS_W'(i)) != '0);
			above[i] = live[i] && (PASS_W'(i) > pass_q);
		end
	end

	assign first_pass = lowest(live);
	assign next_pass  = lowest(above);
	assign next_found = |above;
	assign empty      = ~|live;

	assign row_inc    = {1'b0, row_q} + 1'b1;
	assign col_inc    = {1'b0, col_q} + 1'b1;
	assign row_done   = row_inc >= {1'b0, cur_rows};
	assign frame_done = row_done && !next_found;
	assign cols_zero  = cur_cols == '0;
	assign pix_done   = col_inc >= {1'b0, cur_cols};

	assign in_ready = !q_full && !fixup_q;
	assign accept   = in_valid && in_ready;
	assign eos      = accept && !empty &&
		((expect_q && cols_zero) || (!expect_q && bip_q == BYTE_3 && pix_done));

	// Classify the byte and build its queue entry
	always_comb begin
		q_push         = 1'b0;
		q_entry.triple = 1'b0;
		q_entry.b0     = in_byte;
		q_entry.b1     = held2_q;
		q_entry.b2     = held1_q;
		q_entry.filt   = 1'b0;
		q_entry.fend   = 1'b0;
		if (accept && !empty) begin
			if (expect_q) begin
				q_push       = 1'b1;
				q_entry.filt = 1'b1;
				q_entry.fend = cols_zero && frame_done;
			end else begin
				case (bip_q)
					BYTE_2: begin
						q_push         = 1'b1;
						q_entry.triple = 1'b1;
					end
					BYTE_3: begin
						q_push       = 1'b1;
						q_entry.fend = pix_done && frame_done;
					end
					default: q_push = 1'b0;
				endcase
			end
		end
	end

	// Advance configuration and scanline position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			ilace_q  <= 1'b0;
			pass_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			bip_q    <= BYTE_0;
			expect_q <= 1'b1;
			fixup_q  <= 1'b0;
		end else if (cfg_known) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default:          ilace_q  <= cfg_data[0];
			endcase
			pass_q   <= '0;
			row_q    <= '0;
			col_q    <= '0;
			bip_q    <= BYTE_0;
			expect_q <= 1'b1;
			fixup_q  <= 1'b1;
		end else if (fixup_q) begin
			// settle the first pass once the new geometry is in place
			pass_q  <= first_pass;
			fixup_q <= 1'b0;
		end else if (eos) begin
			expect_q <= 1'b1;
			col_q    <= '0;
			bip_q    <= BYTE_0;
			if (!row_done) begin
				row_q <= row_inc[DIM_BITS-1:0];
			end else begin
				row_q  <= '0;
				pass_q <= next_found ? next_pass : first_pass;
			end
		end else if (accept && !empty) begin
			if (expect_q) begin
				expect_q <= 1'b0;
				col_q    <= '0;
				bip_q    <= BYTE_0;
			end else begin
				case (bip_q)
					BYTE_0: bip_q <= BYTE_1;
					BYTE_1: bip_q <= BYTE_2;
					BYTE_2: bip_q <= BYTE_3;
					default: begin
						bip_q <= BYTE_0;
						col_q <= col_inc[DIM_BITS-1:0];
					end
				endcase
			end
		end
	end

	// Hold the first two bytes of a pixel
	always_ff @(posedge clk) begin
		if (accept && !empty && !expect_q && !fixup_q) begin
			if (bip_q == BYTE_0)
				held1_q <= in_byte;
			if (bip_q == BYTE_1)
				held2_q <= in_byte;
		end
	end

endmodule

[rtl/pacs_queue.sv]
// ----------------------------------------------------------------------------
// pacs_queue
// Short show-ahead queue of result groups between front and back.
// ----------------------------------------------------------------------------
module pacs_queue import pacs_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   full,
	input  logic   pop,
	output entry_t rd_entry,
	output logic   empty
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full     = count_q == (QPTR_W+1)'(QDEPTH);
	assign empty    = count_q == '0;
	assign rd_entry = mem_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_entry;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/pacs_back.sv]
// ----------------------------------------------------------------------------
// pacs_back
// Expands queued result groups into single output bytes, one per cycle
// while out_ready allows, through an output register.
// ----------------------------------------------------------------------------
module pacs_back import pacs_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  entry_t     q_entry,
	input  logic       q_empty,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       is_filter_byte,
	output logic       frame_end
);

	logic       out_valid_q;
	logic [1:0] pend_cnt_q;
	logic [7:0] pend1_q, pend2_q;
	logic [7:0] out_byte_q;
	logic       last_q, filt_q, fend_q;
	logic       advance;

	assign advance = !out_valid_q || out_ready;
	assign q_pop   = advance && pend_cnt_q == '0 && !q_empty;

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign run_last       = last_q;
	assign is_filter_byte = filt_q;
	assign frame_end      = fend_q;

	// Output valid and count of bytes still owed by a three-byte group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_cnt_q  <= '0;
		end else if (advance) begin
			if (pend_cnt_q != '0) begin
				out_valid_q <= 1'b1;
				pend_cnt_q  <= pend_cnt_q - 1'b1;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				pend_cnt_q  <= q_entry.triple ? 2'd2 : 2'd0;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register and shift the owed bytes
	always_ff @(posedge clk) begin
		if (advance) begin
			if (pend_cnt_q != '0) begin
				out_byte_q <= pend1_q;
				last_q     <= pend_cnt_q == 2'd1;
				filt_q     <= 1'b0;
				fend_q     <= 1'b0;
				pend1_q    <= pend2_q;
			end else if (!q_empty) begin
				out_byte_q <= q_entry.b0;
				last_q     <= !q_entry.triple;
				filt_q     <= q_entry.filt;
				fend_q     <= q_entry.fend;
				pend1_q    <= q_entry.b1;
				pend2_q    <= q_entry.b2;
			end
		end
	end

endmodule

[verif/png_adam7_channel_swap_unit_checker.sv]
// ----------------------------------------------------------------------------
// png_adam7_channel_swap_unit_checker
// Watches the configuration, input and output channels of the channel swap
// unit. It keeps its own copy of the image geometry and scanline position,
// works out the bytes that each accepted input byte should release, and
// compares every output transaction, field by field, with the oldest of them.
// ----------------------------------------------------------------------------
module png_adam7_channel_swap_unit_checker import pacs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [7:0]           in_byte,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [7:0]           out_byte,
	input  logic                 run_last,
	input  logic                 is_filter_byte,
	input  logic                 frame_end,
	output int                   mismatches,
	output int                   pending,
	output int                   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ADAM_PASSES = 7;
	localparam int PASS_X0 [ADAM_PASSES] = '{0, 4, 0, 2, 0, 1, 0};
	localparam int PASS_DX [ADAM_PASSES] = '{8, 8, 4, 4, 2, 2, 1};
	localparam int PASS_Y0 [ADAM_PASSES] = '{0, 0, 4, 0, 2, 0, 1};
	localparam int PASS_DY [ADAM_PASSES] = '{8, 8, 8, 4, 4, 2, 2};

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       filt;
		logic       fend;
	} swap_result_t;

	// Bytes still owed by the block, oldest first
	swap_result_t swapped_q [$];

	// Geometry registers
	logic [15:0] width_px;
	logic [15:0] height_px;
	logic        adam7;

	// Scanline position and the held blue and green bytes of a pixel
	logic [7:0]  blue_hold;
	logic [7:0]  green_hold;
	logic [2:0]  pass_idx;
	logic [15:0] row_idx;
	logic [15:0] col_idx;
	logic [1:0]  pixel_phase;
	logic        want_filter;

	function automatic int axis_span(int size, int start, int step);
		if (size <= start)
			return 0;
		return (size - start + step - 1) / step;
	endfunction

	function automatic int cols_in(int p);
		if (!adam7)
			return width_px;
		return axis_span(width_px, PASS_X0[p], PASS_DX[p]);
	endfunction

	// A pass with no columns carries no scanlines at all
	function automatic int rows_in(int p);
		if (!adam7)
			return height_px;
		if (cols_in(p) == 0)
			return 0;
		return axis_span(height_px, PASS_Y0[p], PASS_DY[p]);
	endfunction

	function automatic int first_pass_from(int p);
		int top;
		top = adam7 ? ADAM_PASSES : 1;
		for (int q = p; q < top; q++) begin
			if (rows_in(q) != 0)
				return q;
		end
		return ADAM_PASSES;
	endfunction

	function automatic void restart_frame();
		int p;
		p = first_pass_from(0);
		blue_hold   = '0;
		green_hold  = '0;
		pass_idx    = (p < ADAM_PASSES) ? 3'(p) : 3'd0;
		row_idx     = '0;
		col_idx     = '0;
		pixel_phase = '0;
		want_filter = 1'b1;
	endfunction

	// Close the scanline; tell whether it closed the frame
	function automatic bit finish_scanline();
		int p;
		want_filter = 1'b1;
		col_idx     = '0;
		pixel_phase = '0;
		row_idx     = row_idx + 16'd1;
		if (row_idx < rows_in(pass_idx))
			return 1'b0;
		row_idx = '0;
		p = first_pass_from(pass_idx + 1);
		if (p < ADAM_PASSES) begin
			pass_idx = 3'(p);
			return 1'b0;
		end
		restart_frame();
		return 1'b1;
	endfunction

	function automatic void apply_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		case (idx)
			REG_IMAGE_WIDTH:  width_px  = value;
			REG_IMAGE_HEIGHT: height_px = value;
			REG_INTERLACE_ON: adam7     = value[0];
			default:          return;
		endcase
		restart_frame();
	endfunction

	// Queue the bytes that one input byte releases
	function automatic void predict_byte(logic [7:0] b);
		int cols;
		bit fend;
		if (first_pass_from(0) >= ADAM_PASSES)
			return;
		cols = cols_in(pass_idx);
		if (want_filter) begin
			fend = 1'b0;
			if (cols == 0) begin
				fend = finish_scanline();
			end else begin
				want_filter = 1'b0;
				col_idx     = '0;
				pixel_phase = '0;
			end
			swapped_q.push_back(swap_result_t'{b, 1'b1, 1'b1, fend});
			return;
		end
		case (pixel_phase)
			2'd0: begin
				blue_hold   = b;
				pixel_phase = 2'd1;
			end
			2'd1: begin
				green_hold  = b;
				pixel_phase = 2'd2;
			end
			2'd2: begin
				swapped_q.push_back(swap_result_t'{b, 1'b0, 1'b0, 1'b0});
				swapped_q.push_back(swap_result_t'{green_hold, 1'b0, 1'b0, 1'b0});
				swapped_q.push_back(swap_result_t'{blue_hold, 1'b1, 1'b0, 1'b0});
				pixel_phase = 2'd3;
			end
			default: begin
				fend        = 1'b0;
				pixel_phase = 2'd0;
				col_idx     = col_idx + 16'd1;
				if (col_idx >= cols)
					fend = finish_scanline();
				swapped_q.push_back(swap_result_t'{b, 1'b1, 1'b0, fend});
			end
		endcase
	endfunction

	function automatic void note_failure(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s", $time, what);
	endfunction

	// Compare one output transaction with the oldest expected byte
	function automatic void check_result();
		swap_result_t want;
		checked++;
		if (swapped_q.size() == 0) begin
			note_failure($sformatf("unexpected output: byte %02h last %b filt %b fend %b",
				out_byte, run_last, is_filter_byte, frame_end));
			return;
		end
		want = swapped_q.pop_front();
		if (out_byte !== want.data || run_last !== want.last ||
				is_filter_byte !== want.filt || frame_end !== want.fend)
			note_failure($sformatf({"output %0d mismatch: expected byte %02h last %b filt %b ",
				"fend %b, got byte %02h last %b filt %b fend %b"}, checked,
				want.data, want.last, want.filt, want.fend,
				out_byte, run_last, is_filter_byte, frame_end));
	endfunction

	// Track every transaction on the three channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_px   = '0;
			height_px  = '0;
			adam7      = 1'b0;
			restart_frame();
			swapped_q.delete();
			mismatches = 0;
			checked    = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				apply_write(cfg_index, cfg_data);
			if (in_valid && in_ready)
				predict_byte(in_byte);
			if (out_valid && out_ready)
				check_result();
		end
		pending = swapped_q.size();
	end

endmodule

[verif/png_adam7_channel_swap_unit_tb.sv]
// ----------------------------------------------------------------------------
// png_adam7_channel_swap_unit_tb
// Drives the channel swap unit with a short directed sequence (empty images,
// filter-only scanlines, frame wrap, ignored register writes) and then with
// random frames in plain and Adam7 order, mostly whole frames with random
// pixel data, some cut short. Both sides stall at random; the checker beside
// the block predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module png_adam7_channel_swap_unit_tb import pacs_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 10;
	localparam int RANDOM_BYTES  = 75;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 cfg_valid      = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index      = '0;
	logic [15:0]          cfg_data       = '0;
	logic                 in_valid       = 1'b0;
	logic                 in_ready;
	logic [7:0]           in_byte        = '0;
	logic                 out_valid;
	logic                 out_ready      = 1'b0;
	logic [7:0]           out_byte;
	logic                 run_last;
	logic                 is_filter_byte;
	logic                 frame_end;

	int mismatches;
	int pending;
	int checked;

	// Stimulus bookkeeping
	bit no_gaps     = 1'b0;
	int bytes_sent  = 0;
	int reg_writes  = 0;
	int frames_run  = 0;

	png_adam7_channel_swap_unit DUT (.*);

	png_adam7_channel_swap_unit_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Input bytes needed for one whole frame of the given geometry
	function automatic int frame_bytes(int w, int h, bit il);
		int total;
		int c;
		int r;
		if (!il)
			return h * (1 + 4 * w);
		total = 0;
		for (int p = 0; p < NUM_PASSES; p++) begin
			c = (w > ADAM_X0[p]) ? (w - ADAM_X0[p] + (1 << ADAM_XSH[p]) - 1) >> ADAM_XSH[p] : 0;
			r = (h > ADAM_Y0[p]) ? (h - ADAM_Y0[p] + (1 << ADAM_YSH[p]) - 1) >> ADAM_YSH[p] : 0;
			if (c != 0)
				total += r * (1 + 4 * c);
		end
		return total;
	endfunction

	// Offer one byte, after a random hold-off, and wait for its transaction
	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_random(int count);
		repeat (count) send_byte(8'($urandom));
	endtask

	// Drop valid and let the block empty out
	task automatic drain(int cycles);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (cycles) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		reg_writes++;
	endtask

	// Set the whole geometry once the block is idle
	task automatic configure(logic [15:0] w, logic [15:0] h, bit il);
		drain(SETTLE_CYCLES);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_INTERLACE_ON, {15'($urandom), il});
		frames_run++;
	endtask

	// Output side: hold ready low for a random number of cycles per transaction
	initial begin
		int gap;
		gap = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gap > 0) begin
				out_ready <= 1'b0;
				gap--;
			end else begin
				out_ready <= 1'b1;
			end
			@(posedge clk);
			if (out_ready && out_valid)
				gap = no_gaps ? 0 : $urandom_range(0, 9);
		end
	end

	// Reset and stimulus
	initial begin
		int w;
		int h;
		int len;
		int room;
		int rand_sent;
		bit il;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One pixel, plain rows, then wrap into the next frame
		configure(16'd1, 16'd1, 1'b0);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h00);
		send_byte(8'hff);
		send_byte(8'h80);
		send_byte(8'hff);

		// Zero width: filter-only scanlines
		configure(16'd0, 16'd2, 1'b0);
		send_byte(8'h04);
		send_byte(8'h01);

		// Empty images are swallowed whole
		configure(16'd3, 16'd0, 1'b0);
		send_byte(8'h5a);
		send_byte(8'ha5);
		configure(16'd5, 16'd0, 1'b1);
		send_byte(8'h3c);

		// Single-pixel Adam7 image: only the first pass has a scanline
		configure(16'd1, 16'd1, 1'b1);
		send_random(5);

		// An unknown register index must not restart the frame
		configure(16'd2, 16'd1, 1'b0);
		send_byte(8'h02);
		send_byte(8'h11);
		send_byte(8'h22);
		drain(SETTLE_CYCLES);
		write_reg(REG_UNUSED, 16'hffff);
		send_random(6);

		// Random frames; the first is big enough to visit all seven passes
		rand_sent = 0;
		while (rand_sent < RANDOM_BYTES) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			if (frames_run == 6) begin
				w  = 5;
				h  = 5;
				il = 1'b1;
			end else begin
				w  = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
				h  = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
				il = 1'(($urandom_range(0, 1)));
			end
			configure(16'(w), 16'(h), il);
			if ($urandom_range(0, 7) == 0) begin
				drain(SETTLE_CYCLES);
				write_reg(REG_UNUSED, 16'($urandom));
			end
			len  = frame_bytes(w, h, il);
			room = RANDOM_BYTES - rand_sent;
			if (len == 0) begin
				// Noise into an empty image
				send_random(2);
			end else if ($urandom_range(0, 3) == 0) begin
				// Cut the frame short; the next write restarts it
				len = $urandom_range(1, len);
				len = (len > room) ? room : len;
				send_random(len);
				rand_sent += len;
			end else begin
				// Whole frame, sometimes running on into the next one
				if ($urandom_range(0, 2) == 0)
					len += $urandom_range(1, 6);
				len = (len > room) ? room : len;
				send_random(len);
				rand_sent += len;
			end
		end

		// Largest geometry in both orders, first scanline only
		no_gaps = 1'b0;
		configure(16'hffff, 16'hffff, 1'b0);
		send_random(6);
		configure(16'hffff, 16'hffff, 1'b1);
		send_random(6);

		drain(SETTLE_CYCLES * 2);
		$display("Ran %0d geometries with %0d register writes and %0d input bytes;",
			frames_run, reg_writes, bytes_sent);
		$display("%0d output transactions compared, %0d mismatches.", checked, mismatches);
		if (mismatches == 0) begin
			$display("png_adam7_channel_swap_unit test passed");
		end else begin
			$display("png_adam7_channel_swap_unit test failed");
		end
		$finish;
	end

	// Give up if the run hangs
	initial begin
		#5ms;
		$display("Timed out with %0d output transactions outstanding.", pending);
		$display("png_adam7_channel_swap_unit test failed");
		$finish;
	end

endmodule
